FILE: rtl/core/nta_pkg.sv
// Shared types, codes and reset values for the nearest track association block.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package nta_pkg;

    localparam int TRACK_SLOTS_DEF = 16;

    localparam int POS_W    = 10;
    localparam int ENERGY_W = 17;
    localparam int DECAY_W  = 16;
    localparam int BIRTH_W  = 32;
    localparam int SLOT_W   = 4;
    localparam int MASK_W   = 16;
    localparam int CFG_W    = 17;
    localparam int CIDX_W   = 2;
    localparam int PROD_W   = ENERGY_W + DECAY_W;
    localparam int SQ_W     = 2 * POS_W;

    localparam logic [ENERGY_W-1:0] ENERGY_ONE = ENERGY_W'(65536);

    localparam logic [POS_W-1:0]    RADIUS_RST = POS_W'(80);
    localparam logic [DECAY_W-1:0]  DECAY_RST  = DECAY_W'(59310);
    localparam logic [ENERGY_W-1:0] STEP_RST   = ENERGY_W'(13107);
    localparam logic [ENERGY_W-1:0] FLOOR_RST  = ENERGY_W'(655);

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_POINT = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [1:0] OUT_MATCH = 2'd0;
    localparam logic [1:0] OUT_NEW   = 2'd1;
    localparam logic [1:0] OUT_NONE  = 2'd2;
    localparam logic [1:0] OUT_FRAME = 2'd3;

    localparam logic [CIDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_DECAY  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_STEP   = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_FLOOR  = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0]    x;
        logic [POS_W-1:0]    y;
        logic [ENERGY_W-1:0] energy;
        logic [BIRTH_W-1:0]  birth;
    } t_track;

endpackage

FILE: rtl/core/nearest_track_association.sv
// Nearest track association: slot table memory, one shared multiplier, scan sequencer.
// Depends on nta_pkg for widths, codes, reset values and the slot record type.
//
//   channel   direction  handshake                  payload
//   in        input      i_in_valid / o_in_ready    i_kind i_point_x i_point_y i_time_stamp
//   out       output     o_out_valid / i_out_ready  o_slot o_outcome o_active_mask
//   cfg       input      i_cfg_we                   i_cfg_index i_cfg_data
//
// One item in flight; o_in_ready is high only while the sequencer is idle.
// Frame start scans every slot once, decaying its energy through the multiplier; frame end scans
// every slot once. A point scans every slot for the nearest match and, when none is placed,
// scans again for the oldest slot; dx and dy squares of each slot share the one multiplier.
// A finished item waits in the output register; a stalled output holds the sequencer
// in its final state. Reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps

module nearest_track_association #(
    parameter int TRACK_SLOTS = nta_pkg::TRACK_SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_kind,
    input  logic [nta_pkg::POS_W-1:0]    i_point_x,
    input  logic [nta_pkg::POS_W-1:0]    i_point_y,
    input  logic [nta_pkg::BIRTH_W-1:0]  i_time_stamp,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [nta_pkg::SLOT_W-1:0]   o_slot,
    output logic [1:0]                   o_outcome,
    output logic [nta_pkg::MASK_W-1:0]   o_active_mask,
    input  logic                         i_cfg_we,
    input  logic [nta_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [nta_pkg::CFG_W-1:0]    i_cfg_data
);
    import nta_pkg::*;

    localparam int IW = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
    localparam logic [IW-1:0] LAST = IW'(TRACK_SLOTS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRIME = 3'd1;
    localparam logic [2:0] S_DECAY = 3'd2;
    localparam logic [2:0] S_NEAR  = 3'd3;
    localparam logic [2:0] S_DEC   = 3'd4;
    localparam logic [2:0] S_OLD   = 3'd5;
    localparam logic [2:0] S_END   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [POS_W-1:0]    r_radius;
    logic [DECAY_W-1:0]  r_decay;
    logic [ENERGY_W-1:0] r_step;
    logic [ENERGY_W-1:0] r_floor;

    t_track                 r_mem [TRACK_SLOTS];
    logic [TRACK_SLOTS-1:0] r_mv;
    logic [TRACK_SLOTS-1:0] r_nz;
    logic [TRACK_SLOTS-1:0] r_found;
    t_track                 r_q;
    logic                   r_qv;

    logic [2:0]          r_state;
    logic                r_ph;
    logic [IW-1:0]       r_cnt;
    logic [1:0]          r_kind;
    logic [POS_W-1:0]    r_px;
    logic [POS_W-1:0]    r_py;
    logic [BIRTH_W-1:0]  r_ts;
    logic [PROD_W-1:0]   r_acc;
    logic [SQ_W-1:0]     r_r2;
    logic [POS_W-1:0]    r_dy;
    logic                r_elig;
    logic [ENERGY_W-1:0] r_ek;
    t_track              r_word;
    logic                r_have;
    logic [IW-1:0]       r_best;
    logic [SQ_W:0]       r_bd2;
    logic [ENERGY_W-1:0] r_be;
    logic                r_of;
    logic [IW-1:0]       r_old;
    logic [BIRTH_W-1:0]  r_ob;
    logic [IW-1:0]       r_rslot;
    logic [1:0]          r_rout;

    t_track              q;
    logic [IW-1:0]       rd_addr;
    logic [ENERGY_W-1:0] mul_a;
    logic [DECAY_W-1:0]  mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [POS_W-1:0]    dx;
    logic [POS_W-1:0]    dy;
    logic [SQ_W:0]       d2;
    logic [ENERGY_W-1:0] step_v;
    logic [ENERGY_W:0]   esum;
    logic [ENERGY_W-1:0] e_match;
    logic                w_en;
    logic [IW-1:0]       w_addr;
    t_track              w_data;
    logic                w_place;
    logic                in_acc;
    logic                out_load;
    logic [MASK_W-1:0]   mask;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign out_load   = (r_state == S_FIN) && (!o_out_valid || i_out_ready);

    assign q       = r_qv ? r_q : '0;
    assign rd_addr = (r_ph && (r_state != S_PRIME) && (r_state != S_DEC))
                     ? ((r_cnt == LAST) ? '0 : r_cnt + IW'(1)) : r_cnt;

    assign dx = (q.x > r_px) ? q.x - r_px : r_px - q.x;
    assign dy = (q.y > r_py) ? q.y - r_py : r_py - q.y;

    assign step_v  = (r_step > ENERGY_ONE) ? ENERGY_ONE : r_step;
    assign esum    = {1'b0, r_be} + {1'b0, step_v};
    assign e_match = (esum > {1'b0, ENERGY_ONE}) ? ENERGY_ONE : esum[ENERGY_W-1:0];

    // shared multiplier: radius square, dx and dy squares, energy decay
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_PRIME: begin
                mul_a = ENERGY_W'(r_radius);
                mul_b = DECAY_W'(r_radius);
            end
            S_DECAY: begin
                mul_a = q.energy;
                mul_b = r_decay;
            end
            S_NEAR: begin
                mul_a = r_ph ? ENERGY_W'(r_dy) : ENERGY_W'(dx);
                mul_b = r_ph ? DECAY_W'(r_dy) : DECAY_W'(dx);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;
    assign d2    = {1'b0, r_acc[SQ_W-1:0]} + {1'b0, mul_p[SQ_W-1:0]};

    assign w_place = ((r_state == S_DEC) && r_have && (r_bd2 < {1'b0, r_r2}))
                     || ((r_state == S_OLD) && r_ph && (r_cnt == LAST) && r_of);

    always_comb begin
        w_en   = 1'b0;
        w_addr = r_cnt;
        w_data = r_word;
        if (w_place) begin
            w_en     = 1'b1;
            w_addr   = (r_state == S_DEC) ? r_best : r_old;
            w_data.x = r_px;
            w_data.y = r_py;
            w_data.energy = (r_state == S_DEC) ? e_match : step_v;
            w_data.birth  = r_ts;
        end else if (r_ph && (r_state == S_DECAY)) begin
            w_en          = 1'b1;
            w_data.energy = r_acc[PROD_W-1:DECAY_W];
        end else if (r_ph && (r_state == S_END) && !r_found[r_cnt]) begin
            w_en          = 1'b1;
            w_data.energy = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_q <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
            r_decay  <= DECAY_RST;
            r_step   <= STEP_RST;
            r_floor  <= FLOOR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RADIUS: r_radius <= i_cfg_data[POS_W-1:0];
                CFG_DECAY:  r_decay  <= i_cfg_data[DECAY_W-1:0];
                CFG_STEP:   r_step   <= i_cfg_data;
                CFG_FLOOR:  r_floor  <= i_cfg_data;
                default:    r_floor  <= r_floor;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv    <= '0;
            r_nz    <= '0;
            r_found <= '0;
            r_qv    <= 1'b0;
        end else begin
            r_qv <= r_mv[rd_addr];
            if (w_en) begin
                r_mv[w_addr] <= 1'b1;
                r_nz[w_addr] <= (w_data.energy != '0);
            end
            if (in_acc && (i_kind == KIND_START)) begin
                r_found <= '0;
            end else if (w_place) begin
                r_found[w_addr] <= 1'b1;
            end
        end
    end

    // datapath registers of the scan
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind <= i_kind;
            r_px   <= i_point_x;
            r_py   <= i_point_y;
            r_ts   <= i_time_stamp;
        end
        r_word <= q;
        case (r_state)
            S_PRIME: begin
                r_r2   <= mul_p[SQ_W-1:0];
                r_have <= 1'b0;
                r_of   <= 1'b0;
            end
            S_DECAY: begin
                if (!r_ph) begin
                    r_acc <= mul_p;
                end
            end
            S_NEAR: begin
                if (!r_ph) begin
                    r_acc  <= mul_p;
                    r_dy   <= dy;
                    r_elig <= !(q.energy < r_floor) && !r_found[r_cnt];
                    r_ek   <= q.energy;
                end else if (r_elig && (!r_have || (d2 < r_bd2))) begin
                    r_have <= 1'b1;
                    r_best <= r_cnt;
                    r_bd2  <= d2;
                    r_be   <= r_ek;
                end
            end
            S_OLD: begin
                if (!r_ph && !r_found[r_cnt] && (!r_of || (q.birth < r_ob))) begin
                    r_of  <= 1'b1;
                    r_old <= r_cnt;
                    r_ob  <= q.birth;
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= 1'b0;
            r_cnt   <= '0;
            r_rslot <= '0;
            r_rout  <= OUT_FRAME;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_ph    <= 1'b0;
                    r_cnt   <= '0;
                    r_rslot <= '0;
                    r_rout  <= OUT_FRAME;
                    if (in_acc) begin
                        case (i_kind)
                            KIND_START, KIND_POINT, KIND_END: r_state <= S_PRIME;
                            default:                          r_state <= S_FIN;
                        endcase
                    end
                end
                S_PRIME: begin
                    case (r_kind)
                        KIND_START: r_state <= S_DECAY;
                        KIND_POINT: r_state <= S_NEAR;
                        default:    r_state <= S_END;
                    endcase
                end
                S_DECAY, S_END, S_NEAR, S_OLD: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_cnt <= (r_cnt == LAST) ? '0 : r_cnt + IW'(1);
                        if (r_cnt == LAST) begin
                            case (r_state)
                                S_NEAR:  r_state <= S_DEC;
                                S_OLD: begin
                                    r_state <= S_FIN;
                                    r_rslot <= r_of ? r_old : '0;
                                    r_rout  <= r_of ? OUT_NEW : OUT_NONE;
                                end
                                default: r_state <= S_FIN;
                            endcase
                        end
                    end
                end
                S_DEC: begin
                    r_ph <= 1'b0;
                    if (w_place) begin
                        r_state <= S_FIN;
                        r_rslot <= r_best;
                        r_rout  <= OUT_MATCH;
                    end else begin
                        r_state <= S_OLD;
                    end
                end
                S_FIN: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    for (genvar g = 0; g < MASK_W; g++) begin : g_mask
        if (g < TRACK_SLOTS) begin : g_on
            assign mask[g] = r_nz[g];
        end else begin : g_off
            assign mask[g] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_slot        <= SLOT_W'(r_rslot);
            o_outcome     <= r_rout;
            o_active_mask <= mask;
        end
    end

endmodule

FILE: rtl/core/nta_checker.sv
// Port-level checker for nearest_track_association, bound to the top level.
// Depends on nta_pkg for field widths and outcome codes.
`timescale 1ns / 1ps

module nta_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic [1:0]                   i_kind,
    input logic [nta_pkg::POS_W-1:0]    i_point_x,
    input logic [nta_pkg::POS_W-1:0]    i_point_y,
    input logic [nta_pkg::BIRTH_W-1:0]  i_time_stamp,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [nta_pkg::SLOT_W-1:0]   o_slot,
    input logic [1:0]                   o_outcome,
    input logic [nta_pkg::MASK_W-1:0]   o_active_mask,
    input logic                         i_cfg_we,
    input logic [nta_pkg::CIDX_W-1:0]   i_cfg_index,
    input logic [nta_pkg::CFG_W-1:0]    i_cfg_data
);
    import nta_pkg::*;

    logic unused_ok;
    assign unused_ok = ^{i_kind, i_point_x, i_point_y, i_time_stamp,
                         i_cfg_we, i_cfg_index, i_cfg_data};

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after an accepted item");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !$rose(o_out_valid))
        else $error("result appeared in the cycle after accept");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_outcome == OUT_FRAME) || (o_outcome == OUT_NONE)))
        |-> (o_slot == '0))
        else $error("nonzero slot on frame or no-free-slot result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_slot) && $stable(o_outcome) && $stable(o_active_mask)))
        else $error("stalled result changed");

endmodule

bind nearest_track_association nta_checker u_nta_checker (.*);
